// ===== rtl/core/dng_olp_pkg.sv =====
package dng_olp_pkg;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_ELEMENT = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OP_LEN    = 2'd1;
    localparam logic [1:0] ST_TOTAL_LEN = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] opcode_number;
        logic [31:0] opcode_id;
        logic        is_optional;
        logic        skip_in_preview;
        logic [31:0] element_number;
        logic [63:0] element_bits;
        logic [3:0]  element_bytes;
        logic [1:0]  status;
        logic        run_end;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic step;
        logic chk1;
        logic chk2;
        logic chk3;
        logic load_a;
        logic load_s;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic chk_need;
        logic has_pend;
        logic fin;
        logic st_ok;
    } t_dp_stat;

    function automatic logic is_known(input logic [31:0] id);
        return (id >= 32'd1 && id <= 32'd9) || id == 32'd14;
    endfunction

    function automatic logic is_fixed(input logic [31:0] id);
        return id == 32'd3 || id == 32'd4 || id == 32'd6;
    endfunction

    function automatic logic [6:0] prefix_len(input logic [31:0] id);
        logic [6:0] r;
        r = 7'd0;
        if (id == 32'd1 || id == 32'd2 || id == 32'd14) r = 7'd4;
        else if (id == 32'd3) r = 7'd56;
        else if (id == 32'd4) r = 7'd8;
        else if (id == 32'd5) r = 7'd12;
        else if (id == 32'd6) r = 7'd16;
        else if (id == 32'd7 || id == 32'd8) r = 7'd36;
        else if (id == 32'd9) r = 7'd76;
        return r;
    endfunction

    function automatic logic has_prefix(input logic [31:0] id);
        return id == 32'd1 || id == 32'd2 || id == 32'd5 || id == 32'd7 ||
               id == 32'd8 || id == 32'd9 || id == 32'd14;
    endfunction

    function automatic logic [3:0] prefix_last(input logic [31:0] id);
        logic [3:0] r;
        r = 4'd0;
        if (id == 32'd5) r = 4'd2;
        else if (id == 32'd7 || id == 32'd8) r = 4'd8;
        else if (id == 32'd9) r = 4'd14;
        return r;
    endfunction

    function automatic logic [3:0] elem_width(input logic [31:0] id,
                                              input logic [31:0] e,
                                              input logic [31:0] rem);
        logic [3:0] r;
        r = 4'd4;
        if (id == 32'd1 || id == 32'd2) r = (e == 32'd0) ? 4'd4 : 4'd8;
        else if (id == 32'd3) r = 4'd8;
        else if (id == 32'd7) r = (e < 32'd9) ? 4'd4 : 4'd2;
        else if (id == 32'd8) r = (e < 32'd9) ? 4'd4 : 4'd8;
        else if (id == 32'd9) r = (e >= 32'd10 && e <= 32'd13) ? 4'd8 : 4'd4;
        else if (id == 32'd14) r = (e == 32'd0 || rem == 32'd4) ? 4'd4 : 4'd8;
        return r;
    endfunction

endpackage

// ===== rtl/core/dng_olp_dp.sv =====
module dng_olp_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dng_olp_pkg::t_in      i_in_data,
    input  dng_olp_pkg::t_dp_cmd  i_cmd,
    output dng_olp_pkg::t_dp_stat o_stat,
    output dng_olp_pkg::t_out     o_out_data
);
    import dng_olp_pkg::*;

    typedef enum logic [2:0] {
        PH_COUNT, PH_HEADER, PH_PARAMS, PH_SKIP, PH_DONE, PH_ERROR
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_bif, n_bif;
    logic [63:0] r_aw, n_aw;
    logic [31:0] r_left, n_left;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_id, n_id;
    logic [1:0]  r_flags, n_flags;
    logic [31:0] r_size, n_size;
    logic [31:0] r_bc, n_bc;
    logic [31:0] r_c1, n_c1;
    logic [31:0] r_c2, n_c2;
    logic [31:0] r_c3, n_c3;
    logic [31:0] r_ep, n_ep;
    logic [1:0]  r_err, n_err;
    t_out        r_pend, n_pend;
    logic        r_has_pend, n_has_pend;
    logic        r_chk_need, n_chk_need;
    logic        r_fin;
    t_out        r_out;
    logic [63:0] r_hv;
    logic [41:0] r_lin;
    logic [62:0] r_cnt;
    logic        r_big;

    logic [63:0] aw_new;
    logic [3:0]  idx;
    logic [31:0] start;
    logic [3:0]  w;
    logic [3:0]  bif_inc;
    logic        chk_fail;
    logic [1:0]  st;
    t_out        hdr, stat_res;

    assign aw_new  = {r_aw[55:0], i_in_data.byte_value};
    assign idx     = r_bc[3:0];
    assign start   = r_bc - {29'd0, r_bif};
    assign w       = elem_width(r_id, r_ep, r_size - start);
    assign bif_inc = {1'b0, r_bif} + 4'd1;
    assign st      = (r_err != ST_OK) ? r_err :
                     ((r_phase == PH_DONE) ? ST_OK : ST_TOTAL_LEN);

    // Evaluate the opcode length formula
    always_comb begin
        if (r_id == 32'd9) begin
            chk_fail = r_big || (r_cnt > 63'(32'h4000_0000)) ||
                       ((64'd76 + {r_cnt[61:0], 2'b00}) != {32'd0, r_size});
        end else begin
            chk_fail = r_lin != {10'd0, r_size};
        end
    end

    always_comb begin
        stat_res         = '0;
        stat_res.kind    = KIND_STATUS;
        stat_res.status  = st;
        stat_res.run_end = 1'b1;
    end

    // Advance the parse state
    always_comb begin
        n_phase    = r_phase;
        n_bif      = r_bif;
        n_aw       = r_aw;
        n_left     = r_left;
        n_pos      = r_pos;
        n_id       = r_id;
        n_flags    = r_flags;
        n_size     = r_size;
        n_bc       = r_bc;
        n_c1       = r_c1;
        n_c2       = r_c2;
        n_c3       = r_c3;
        n_ep       = r_ep;
        n_err      = r_err;
        n_pend     = r_pend;
        n_has_pend = r_has_pend;
        n_chk_need = r_chk_need;
        hdr        = '0;
        if (i_cmd.step) begin
            n_has_pend = 1'b0;
            n_chk_need = 1'b0;
            unique case (r_phase)
                PH_COUNT: begin
                    n_aw  = aw_new;
                    n_bif = r_bif + 3'd1;
                    if (r_bif == 3'd3) begin
                        n_aw  = '0;
                        n_bif = '0;
                        n_bc  = '0;
                        if (aw_new[31:0] == 32'd0) begin
                            n_err   = ST_EMPTY;
                            n_phase = PH_ERROR;
                        end else begin
                            n_left  = aw_new[31:0];
                            n_phase = PH_HEADER;
                        end
                    end
                end
                PH_HEADER: begin
                    n_aw = aw_new;
                    n_bc = {28'd0, idx} + 32'd1;
                    if (idx[1:0] == 2'd3) begin
                        n_aw = '0;
                        if (idx == 4'd3) n_id = aw_new[31:0];
                        else if (idx == 4'd11) n_flags = aw_new[1:0];
                        else if (idx == 4'd15) n_size = aw_new[31:0];
                    end
                    if (idx == 4'd15) begin
                        n_bc  = '0;
                        n_ep  = '0;
                        n_bif = '0;
                        if (is_known(n_id) &&
                            (is_fixed(n_id) ? n_size != {25'd0, prefix_len(n_id)}
                                            : n_size < {25'd0, prefix_len(n_id)})) begin
                            n_err   = ST_OP_LEN;
                            n_phase = PH_ERROR;
                        end else begin
                            n_phase             = is_known(n_id) ? PH_PARAMS : PH_SKIP;
                            hdr.kind            = KIND_HEADER;
                            hdr.opcode_number   = r_pos;
                            hdr.opcode_id       = n_id;
                            hdr.is_optional     = n_flags[0];
                            hdr.skip_in_preview = n_flags[1];
                            n_pend              = hdr;
                            n_has_pend          = 1'b1;
                            if (!is_known(n_id) && n_size == 32'd0) begin
                                n_left  = r_left - 32'd1;
                                n_pos   = r_pos + 32'd1;
                                n_aw    = '0;
                                n_phase = (r_left != 32'd1) ? PH_HEADER : PH_DONE;
                            end
                        end
                    end
                end
                PH_PARAMS: begin
                    n_aw  = aw_new;
                    n_bc  = r_bc + 32'd1;
                    n_bif = bif_inc[2:0];
                    if (bif_inc >= w) begin
                        if ((r_id == 32'd1 || r_id == 32'd2 || r_id == 32'd14) &&
                            r_ep == 32'd0) n_c1 = aw_new[31:0];
                        if (r_id == 32'd5 && r_ep == 32'd1) n_c1 = aw_new[31:0];
                        if (r_id == 32'd5 && r_ep == 32'd2) n_c2 = aw_new[31:0];
                        if ((r_id == 32'd7 || r_id == 32'd8 || r_id == 32'd9) &&
                            r_ep == 32'd8) n_c1 = aw_new[31:0];
                        if (r_id == 32'd9 && r_ep == 32'd9) n_c2 = aw_new[31:0];
                        if (r_id == 32'd9 && r_ep == 32'd14) n_c3 = aw_new[31:0];
                        hdr.kind            = KIND_ELEMENT;
                        hdr.opcode_number   = r_pos;
                        hdr.opcode_id       = r_id;
                        hdr.is_optional     = r_flags[0];
                        hdr.skip_in_preview = r_flags[1];
                        hdr.element_number  = r_ep;
                        hdr.element_bits    = aw_new;
                        hdr.element_bytes   = w;
                        n_pend              = hdr;
                        n_has_pend          = 1'b1;
                        if (has_prefix(r_id) && r_ep == {28'd0, prefix_last(r_id)}) begin
                            // hold the element until the length check passes
                            n_chk_need = 1'b1;
                        end else begin
                            n_ep  = r_ep + 32'd1;
                            n_aw  = '0;
                            n_bif = '0;
                            if (r_bc + 32'd1 == r_size) begin
                                n_left  = r_left - 32'd1;
                                n_pos   = r_pos + 32'd1;
                                n_bc    = '0;
                                n_ep    = '0;
                                n_phase = (r_left != 32'd1) ? PH_HEADER : PH_DONE;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    n_bc = r_bc + 32'd1;
                    if (r_bc + 32'd1 >= r_size) begin
                        n_left  = r_left - 32'd1;
                        n_pos   = r_pos + 32'd1;
                        n_bc    = '0;
                        n_ep    = '0;
                        n_bif   = '0;
                        n_aw    = '0;
                        n_phase = (r_left != 32'd1) ? PH_HEADER : PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_err   = ST_TOTAL_LEN;
                    n_phase = PH_ERROR;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.chk3) begin
            n_chk_need = 1'b0;
            if (chk_fail) begin
                n_err      = ST_OP_LEN;
                n_phase    = PH_ERROR;
                n_has_pend = 1'b0;
            end else begin
                n_ep  = r_ep + 32'd1;
                n_aw  = '0;
                n_bif = '0;
                if (r_bc == r_size) begin
                    n_left  = r_left - 32'd1;
                    n_pos   = r_pos + 32'd1;
                    n_bc    = '0;
                    n_ep    = '0;
                    n_phase = (r_left != 32'd1) ? PH_HEADER : PH_DONE;
                end
            end
        end else if (i_cmd.load_a) begin
            n_has_pend = 1'b0;
        end
    end

    // Hold parse state; clear it at reset and after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_s) begin
            r_phase    <= PH_COUNT;
            r_bif      <= '0;
            r_aw       <= '0;
            r_left     <= '0;
            r_pos      <= '0;
            r_id       <= '0;
            r_flags    <= '0;
            r_size     <= '0;
            r_bc       <= '0;
            r_c1       <= '0;
            r_c2       <= '0;
            r_c3       <= '0;
            r_ep       <= '0;
            r_err      <= ST_OK;
            r_has_pend <= 1'b0;
            r_chk_need <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_bif      <= n_bif;
            r_aw       <= n_aw;
            r_left     <= n_left;
            r_pos      <= n_pos;
            r_id       <= n_id;
            r_flags    <= n_flags;
            r_size     <= n_size;
            r_bc       <= n_bc;
            r_c1       <= n_c1;
            r_c2       <= n_c2;
            r_c3       <= n_c3;
            r_ep       <= n_ep;
            r_err      <= n_err;
            r_has_pend <= n_has_pend;
            r_chk_need <= n_chk_need;
        end
    end

    // Latch the item flags and the pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= 1'b0;
        end else if (i_cmd.step) begin
            r_fin <= i_in_data.final_byte;
        end
        r_pend <= n_pend;
    end

    // Form the length formula products on chk1 and chk2; chk3 checks the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.chk1) begin
            r_hv <= {32'd0, r_c1} * {32'd0, r_c2};
            if (r_id == 32'd1)
                r_lin <= 42'd20 + 42'd48 * {10'd0, r_c1};
            else if (r_id == 32'd2)
                r_lin <= 42'd20 + 42'd32 * {10'd0, r_c1};
            else if (r_id == 32'd5)
                r_lin <= 42'd12 + 42'd8 * {10'd0, r_c1} + 42'd16 * {10'd0, r_c2};
            else if (r_id == 32'd7)
                r_lin <= 42'd36 + 42'd2 * {10'd0, r_c1};
            else if (r_id == 32'd8)
                r_lin <= 42'd36 + 42'd8 * {10'd0, r_c1};
            else
                r_lin <= 42'd24 + 42'd152 * {10'd0, r_c1};
        end
        if (i_cmd.chk2) begin
            r_big <= (r_c3 != 32'd0) && (r_hv > 64'h4000_0000);
            r_cnt <= (r_c3 == 32'd0) ? 63'd0 : {32'd0, r_hv[30:0]} * {31'd0, r_c3};
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_out         <= r_pend;
            r_out.run_end <= !r_fin;
        end else if (i_cmd.load_s) begin
            r_out <= stat_res;
        end
    end

    assign o_stat.chk_need = r_chk_need;
    assign o_stat.has_pend = r_has_pend;
    assign o_stat.fin      = r_fin;
    assign o_stat.st_ok    = (st == ST_OK);
    assign o_out_data      = r_out;

endmodule

// ===== rtl/core/dng_olp_ctrl.sv =====
module dng_olp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  dng_olp_pkg::t_dp_stat i_stat,
    output dng_olp_pkg::t_dp_cmd  o_cmd
);
    import dng_olp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHK1, S_CHK2, S_CHK3, S_DECIDE, S_OUT_A, S_OUT_S
    } t_state;

    t_state r_state, n_state;
    logic   take_a;

    assign take_a = i_stat.has_pend && !(i_stat.fin && !i_stat.st_ok);

    // Issue commands and pick the next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.chk_need) begin
                    n_state = S_CHK1;
                end else if (take_a) begin
                    o_cmd.load_a = 1'b1;
                    n_state      = S_OUT_A;
                end else if (i_stat.fin) begin
                    o_cmd.load_s = 1'b1;
                    n_state      = S_OUT_S;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CHK1: begin
                o_cmd.chk1 = 1'b1;
                n_state    = S_CHK2;
            end
            S_CHK2: begin
                o_cmd.chk2 = 1'b1;
                n_state    = S_CHK3;
            end
            S_CHK3: begin
                o_cmd.chk3 = 1'b1;
                n_state    = S_DECIDE;
            end
            S_OUT_A: begin
                if (i_out_ready) begin
                    if (i_stat.fin) begin
                        o_cmd.load_s = 1'b1;
                        n_state      = S_OUT_S;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT_S: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_in_ready  <= 1'b1;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            o_in_ready  <= (n_state == S_IDLE);
            o_out_valid <= (n_state == S_OUT_A) || (n_state == S_OUT_S);
        end
    end

endmodule

// ===== rtl/core/dng_opcode_list_parser.sv =====
// Opcode-list parser: takes a DNG opcode-list blob one byte per input item
// and returns header, parameter element and status items.
// Input channel: i_in_valid / o_in_ready with i_in_data (byte, final flag).
// Output channel: o_out_valid / i_out_ready with o_out_data.
// One byte is in work at a time. A byte that yields no result passes
// through the decision state only; a result is loaded into the output
// register there and held until the receiver takes it. The byte that ends
// a parameter prefix runs the opcode length formula through the check
// states S_CHK1, S_CHK2 and S_CHK3 before a second decision, so its result
// is loaded only after the check passes.
// The final byte yields a status item after its own result (or alone
// when it has none or the status is an error) and returns the parser to
// its start state. Reset (synchronous, active low) clears the parse state;
// o_in_ready is set by reset, so the block is ready once reset is released.
// While the receiver stalls, the output item holds and no byte is taken.
module dng_opcode_list_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dng_olp_pkg::t_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dng_olp_pkg::t_out o_out_data
);
    import dng_olp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dng_olp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dng_olp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

// ===== sim/dng_opcode_list_parser_tb.sv =====
module dng_opcode_list_parser_tb;
    import dng_olp_pkg::*;

    // DNG opcode ids with a known parameter layout
    localparam logic [31:0] OP_WARP_RECT     = 32'd1;
    localparam logic [31:0] OP_WARP_FISHEYE  = 32'd2;
    localparam logic [31:0] OP_VIG_RADIAL    = 32'd3;
    localparam logic [31:0] OP_BAD_CONST     = 32'd4;
    localparam logic [31:0] OP_BAD_LIST      = 32'd5;
    localparam logic [31:0] OP_TRIM_BOUNDS   = 32'd6;
    localparam logic [31:0] OP_MAP_TABLE     = 32'd7;
    localparam logic [31:0] OP_MAP_POLY      = 32'd8;
    localparam logic [31:0] OP_GAIN_MAP      = 32'd9;
    localparam logic [31:0] OP_WARP_RECT2    = 32'd14;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum logic [2:0] {
        PH_COUNT, PH_HEADER, PH_PARAMS, PH_SKIP, PH_DONE, PH_ERROR
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    dng_opcode_list_parser uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    t_in  byte_q[$];
    t_out expected_q[$];
    int   mismatches = 0;
    int   cycle_cnt = 0;

    // Parser state mirror
    t_phase      ph;
    int unsigned field_pos;
    logic [63:0] word_acc;
    logic [31:0] ops_left, op_pos, cur_id, decl_size, consumed, elem_pos;
    logic [31:0] cnt_a, cnt_b, cnt_c;
    logic [1:0]  cur_flags, err_code;

    function automatic void clear_parse();
        ph = PH_COUNT;
        field_pos = 0;
        word_acc = '0;
        ops_left = '0;
        op_pos = '0;
        cur_id = '0;
        cur_flags = '0;
        decl_size = '0;
        consumed = '0;
        cnt_a = '0;
        cnt_b = '0;
        cnt_c = '0;
        elem_pos = '0;
        err_code = ST_OK;
    endfunction

    function automatic bit known_op(logic [31:0] id);
        return (id >= OP_WARP_RECT && id <= OP_GAIN_MAP) || id == OP_WARP_RECT2;
    endfunction

    function automatic logic [31:0] fixed_prefix(logic [31:0] id);
        case (id)
            OP_WARP_RECT, OP_WARP_FISHEYE, OP_WARP_RECT2: return 32'd4;
            OP_VIG_RADIAL:                return 32'd56;
            OP_BAD_CONST:                 return 32'd8;
            OP_BAD_LIST:                  return 32'd12;
            OP_TRIM_BOUNDS:               return 32'd16;
            OP_MAP_TABLE, OP_MAP_POLY:    return 32'd36;
            OP_GAIN_MAP:                  return 32'd76;
            default:                      return 32'd0;
        endcase
    endfunction

    // index of the element that closes the prefix, -1 when the size is fixed or the id is unknown
    function automatic int prefix_end(logic [31:0] id);
        case (id)
            OP_WARP_RECT, OP_WARP_FISHEYE, OP_WARP_RECT2: return 0;
            OP_BAD_LIST:               return 2;
            OP_MAP_TABLE, OP_MAP_POLY: return 8;
            OP_GAIN_MAP:               return 14;
            default:                   return -1;
        endcase
    endfunction

    function automatic logic [3:0] width_of(logic [31:0] id, logic [31:0] e,
                                            logic [31:0] rem);
        case (id)
            OP_WARP_RECT, OP_WARP_FISHEYE: return (e == 0) ? 4'd4 : 4'd8;
            OP_VIG_RADIAL: return 4'd8;
            OP_MAP_TABLE:  return (e < 9) ? 4'd4 : 4'd2;
            OP_MAP_POLY:   return (e < 9) ? 4'd4 : 4'd8;
            OP_GAIN_MAP:   return (e >= 10 && e <= 13) ? 4'd8 : 4'd4;
            OP_WARP_RECT2: return (e == 0 || rem == 4) ? 4'd4 : 4'd8;
            default:       return 4'd4;
        endcase
    endfunction

    function automatic void latch_count(logic [31:0] v);
        case (cur_id)
            OP_WARP_RECT, OP_WARP_FISHEYE, OP_WARP_RECT2:
                if (elem_pos == 0) cnt_a = v;
            OP_BAD_LIST: begin
                if (elem_pos == 1) cnt_a = v;
                if (elem_pos == 2) cnt_b = v;
            end
            OP_MAP_TABLE, OP_MAP_POLY:
                if (elem_pos == 8) cnt_a = v;
            OP_GAIN_MAP: begin
                if (elem_pos == 8) cnt_a = v;
                if (elem_pos == 9) cnt_b = v;
                if (elem_pos == 14) cnt_c = v;
            end
            default: ;
        endcase
    endfunction

    // exact length check, no 32-bit wrap
    function automatic bit length_ok();
        longint unsigned a, total, hv, cells;
        a = cnt_a;
        case (cur_id)
            OP_WARP_RECT:    total = 20 + 48 * a;
            OP_WARP_FISHEYE: total = 20 + 32 * a;
            OP_BAD_LIST:     total = 12 + 8 * a + 16 * longint'(cnt_b);
            OP_MAP_TABLE:    total = 36 + 2 * a;
            OP_MAP_POLY:     total = 36 + 8 * a;
            OP_WARP_RECT2:   total = 24 + 152 * a;
            OP_GAIN_MAP: begin
                hv = a * longint'(cnt_b);
                cells = 0;
                if (cnt_c != 0) begin
                    if (hv > (64'd1 << 30)) return 1'b0;
                    cells = hv * longint'(cnt_c);
                    if (cells > (64'd1 << 30)) return 1'b0;
                end
                total = 76 + 4 * cells;
            end
            default: return 1'b1;
        endcase
        return total == longint'(decl_size);
    endfunction

    function automatic void close_opcode();
        ops_left--;
        op_pos++;
        consumed = '0;
        elem_pos = '0;
        field_pos = 0;
        word_acc = '0;
        ph = (ops_left != 0) ? PH_HEADER : PH_DONE;
    endfunction

    function automatic void raise_error(logic [1:0] code);
        err_code = code;
        ph = PH_ERROR;
    endfunction

    function automatic t_out opcode_item(logic [1:0] kind);
        t_out r;
        r = '0;
        r.kind = kind;
        r.opcode_number = op_pos;
        r.opcode_id = cur_id;
        r.is_optional = cur_flags[0];
        r.skip_in_preview = cur_flags[1];
        return r;
    endfunction

    // advance the mirror by one byte and queue the items it yields
    function automatic void parse_byte(t_in it);
        t_out        res[2];
        int          n;
        int unsigned idx;
        logic [31:0] start, cnt;
        logic [3:0]  w;
        logic [1:0]  st;
        bit          ok;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        case (ph)
            PH_COUNT: begin
                word_acc = {word_acc[55:0], it.byte_value};
                field_pos++;
                if (field_pos >= 4) begin
                    cnt = word_acc[31:0];
                    word_acc = '0;
                    field_pos = 0;
                    consumed = '0;
                    if (cnt == 0) raise_error(ST_EMPTY);
                    else begin
                        ops_left = cnt;
                        ph = PH_HEADER;
                    end
                end
            end
            PH_HEADER: begin
                idx = consumed & 15;
                word_acc = {word_acc[55:0], it.byte_value};
                consumed = idx + 1;
                if ((idx & 3) == 3) begin
                    if (idx == 3) cur_id = word_acc[31:0];
                    else if (idx == 11) cur_flags = word_acc[1:0];
                    else if (idx == 15) decl_size = word_acc[31:0];
                    word_acc = '0;
                end
                if (idx == 15) begin
                    consumed = '0;
                    elem_pos = '0;
                    field_pos = 0;
                    if (known_op(cur_id)) begin
                        ok = (prefix_end(cur_id) < 0) ? decl_size == fixed_prefix(cur_id)
                                                      : decl_size >= fixed_prefix(cur_id);
                        if (!ok) raise_error(ST_OP_LEN);
                        else ph = PH_PARAMS;
                    end else begin
                        ph = PH_SKIP;
                    end
                    if (ph != PH_ERROR) begin
                        res[0] = opcode_item(KIND_HEADER);
                        n = 1;
                        if (ph == PH_SKIP && decl_size == 0) close_opcode();
                    end
                end
            end
            PH_PARAMS: begin
                start = consumed - field_pos;
                w = width_of(cur_id, elem_pos, decl_size - start);
                word_acc = {word_acc[55:0], it.byte_value};
                consumed++;
                field_pos++;
                if (field_pos >= w) begin
                    latch_count(word_acc[31:0]);
                    if (int'(elem_pos) == prefix_end(cur_id) && !length_ok()) begin
                        raise_error(ST_OP_LEN);
                    end else begin
                        res[0] = opcode_item(KIND_ELEMENT);
                        res[0].element_number = elem_pos;
                        res[0].element_bits = word_acc;
                        res[0].element_bytes = w;
                        n = 1;
                        elem_pos++;
                        word_acc = '0;
                        field_pos = 0;
                        if (consumed == decl_size) close_opcode();
                    end
                end
            end
            PH_SKIP: begin
                consumed++;
                if (consumed >= decl_size) close_opcode();
            end
            PH_DONE: raise_error(ST_TOTAL_LEN);
            default: ;
        endcase
        // final byte: status item, drop this byte's own item when the list failed
        if (it.final_byte) begin
            if (err_code != ST_OK) st = err_code;
            else st = (ph == PH_DONE) ? ST_OK : ST_TOTAL_LEN;
            if (st != ST_OK) n = 0;
            res[n] = '0;
            res[n].kind = KIND_STATUS;
            res[n].status = st;
            n++;
            clear_parse();
        end
        if (n > 0) res[n-1].run_end = 1'b1;
        for (int k = 0; k < n; k++) expected_q.push_back(res[k]);
    endfunction

    // blob building
    logic [7:0] blob[$];

    function automatic void put_word(logic [31:0] v);
        for (int k = 3; k >= 0; k--) blob.push_back(v[8*k +: 8]);
    endfunction

    function automatic void poke_word(int base, logic [31:0] v);
        for (int k = 0; k < 4; k++) blob[base + k] = v[8*(3-k) +: 8];
    endfunction

    function automatic void queue_blob();
        for (int k = 0; k < blob.size(); k++) begin
            t_in it;
            it.byte_value = blob[k];
            it.final_byte = (k == blob.size() - 1);
            byte_q.push_back(it);
        end
        blob.delete();
    endfunction

    // one opcode: header, parameters; counts fit the size bar a huge gain grid or bad_size
    function automatic void add_opcode(bit bad_size);
        logic [31:0] id, size, a, b, c;
        int          base, pick;
        pick = $urandom_range(0, 11);
        a = $urandom_range(0, 2);
        b = $urandom_range(0, 2);
        c = $urandom_range(0, 2);
        case (pick)
            0: begin id = OP_WARP_RECT;    size = 20 + 48 * a; end
            1: begin id = OP_WARP_FISHEYE; size = 20 + 32 * a; end
            2: begin id = OP_VIG_RADIAL;   size = 56; end
            3: begin id = OP_BAD_CONST;    size = 8; end
            4: begin id = OP_BAD_LIST;     size = 12 + 8 * a + 16 * b; end
            5: begin id = OP_TRIM_BOUNDS;  size = 16; end
            6: begin
                id = OP_MAP_TABLE;
                a = $urandom_range(0, 3);
                size = 36 + 2 * a;
            end
            7: begin id = OP_MAP_POLY;     size = 36 + 8 * a; end
            8: begin
                id = OP_GAIN_MAP;
                if ($urandom_range(0, 7) == 0) begin
                    // grid too large for the length formula
                    a = 32'h0001_0000;
                    b = 32'h0001_0000;
                    c = 32'd1;
                    size = 76;
                end else begin
                    size = 76 + 4 * a * b * c;
                end
            end
            9: begin id = OP_WARP_RECT2;   a = $urandom_range(0, 1); size = 24 + 152 * a; end
            10: begin id = $urandom();     size = $urandom_range(0, 6); end
            default: begin
                id = ($urandom_range(0, 1) != 0) ? 32'd0 : 32'($urandom_range(10, 13));
                size = $urandom_range(0, 6);
            end
        endcase
        put_word(id);
        put_word($urandom());
        put_word($urandom());
        put_word(bad_size ? size ^ (32'd1 << $urandom_range(0, 5)) : size);
        base = blob.size();
        for (int k = 0; k < int'(size); k++) blob.push_back(8'($urandom()));
        case (id)
            OP_WARP_RECT, OP_WARP_FISHEYE, OP_WARP_RECT2: poke_word(base, a);
            OP_BAD_LIST: begin
                poke_word(base + 4, a);
                poke_word(base + 8, b);
            end
            OP_MAP_TABLE, OP_MAP_POLY: poke_word(base + 32, a);
            OP_GAIN_MAP: begin
                poke_word(base + 32, a);
                poke_word(base + 36, b);
                poke_word(base + 72, c);
            end
            default: ;
        endcase
    endfunction

    // half of the lists clean, most others with one defect, some pure noise
    function automatic void add_list();
        int nops, flaw, len;
        nops = $urandom_range(1, 3);
        flaw = $urandom_range(0, 9);
        if (flaw == 4) begin
            len = $urandom_range(1, 24);
            for (int k = 0; k < len; k++) blob.push_back(8'($urandom()));
        end else begin
            if (flaw == 3) put_word(($urandom_range(0, 1) != 0) ? nops + 1 : nops - 1);
            else put_word(nops);
            for (int k = 0; k < nops; k++) add_opcode(flaw == 0 && k == nops - 1);
            if (flaw == 1 && blob.size() > 1) void'(blob.pop_back());
            if (flaw == 2) blob.push_back(8'($urandom()));
        end
        queue_blob();
    endfunction

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // no idling in this window of cycles
    function automatic bit busy_window();
        return cycle_cnt >= 300 && cycle_cnt < 1000;
    endfunction

    // driver: present one byte at a time, mirror each accepted byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) parse_byte(i_in_data);
            if (byte_q.size() > 0 && (busy_window() || $urandom_range(0, 99) >= 16)) begin
                i_in_valid <= 1'b1;
                i_in_data <= byte_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= i_rst_n && (busy_window() || $urandom_range(0, 99) >= 16);
    end

    // monitor: compare each accepted item with the oldest expected one
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: kind %0d status %0d",
                             o_out_data.kind, o_out_data.status);
            end else begin
                want = expected_q.pop_front();
                if (o_out_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp kind %0d op %0d id %h opt %0b prv %0b ",
                                  "el %0d bits %h bytes %0d st %0d end %0b / got kind %0d ",
                                  "op %0d id %h opt %0b prv %0b el %0d bits %h bytes %0d ",
                                  "st %0d end %0b"},
                                 want.kind, want.opcode_number, want.opcode_id,
                                 want.is_optional, want.skip_in_preview,
                                 want.element_number, want.element_bits,
                                 want.element_bytes, want.status, want.run_end,
                                 o_out_data.kind, o_out_data.opcode_number,
                                 o_out_data.opcode_id, o_out_data.is_optional,
                                 o_out_data.skip_in_preview, o_out_data.element_number,
                                 o_out_data.element_bits, o_out_data.element_bytes,
                                 o_out_data.status, o_out_data.run_end);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("dng_opcode_list_parser regression: fail");
            $finish;
        end
    end

    initial begin
        clear_parse();
        // empty list, then one unknown opcode with no parameters
        put_word(32'd0);
        queue_blob();
        put_word(32'd1);
        put_word(32'hFFFF_FFFF);
        put_word(32'd0);
        put_word(32'd3);
        put_word(32'd0);
        queue_blob();
        while (byte_q.size() < 520) add_list();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (byte_q.size() == 0 && !i_in_valid && expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("dng_opcode_list_parser regression: pass");
        end else begin
            $display("dng_opcode_list_parser regression: fail");
        end
        $finish;
    end

endmodule
